// File: src/speed_profile_interpolator_top_assert.svh
// Assertion macros shared by the speed profile interpolator modules.
// The enclosing module must provide clk_i and rst_ni.
`ifndef SPEED_PROFILE_INTERPOLATOR_TOP_ASSERT_SVH
`define SPEED_PROFILE_INTERPOLATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SPI_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");
`define SPI_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`else
`define SPI_ASSERT(name, prop)
`define SPI_ASSERT_MSG(name, prop, msg)
`endif

`endif

// File: src/spi_pkg.sv
`default_nettype none

package spi_pkg;

  localparam int unsigned MAX_SEGMENTS = 16;
  localparam int unsigned SEG_AW       = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned SEG_CW       = $clog2(MAX_SEGMENTS + 1);

  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QUEUE_AW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned QTIME_W      = 32;
  localparam int unsigned TIME_W       = 31;
  localparam int unsigned SPEED_W      = 16;

  // ramp arithmetic widths
  localparam int unsigned DIFF_W       = TIME_W + 1;
  localparam int unsigned DV_W         = SPEED_W + 1;
  localparam int unsigned PROD_W       = DIFF_W + DV_W;
  localparam int unsigned MAG_W        = PROD_W - 1;
  localparam int unsigned DIVISOR_W    = TIME_W;
  localparam int unsigned SUM_W        = MAG_W + 2;
  localparam int unsigned DIV_CNT_W    = $clog2(MAG_W + 1);

  localparam logic [1:0] FUNC_QUERY      = 2'd0;
  localparam logic [1:0] FUNC_APPEND     = 2'd1;
  localparam logic [1:0] FUNC_CLEAR      = 2'd2;

  localparam logic [1:0] MODE_STEP       = 2'd0;
  localparam logic [1:0] MODE_RAMP       = 2'd1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_MODE = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [QTIME_W-1:0] query_time;
    logic [TIME_W-1:0]        seg_end_time;
    logic [SPEED_W-1:0]       seg_end_speed;
    logic [1:0]               seg_mode;
  } in_t;

  typedef struct packed {
    logic [SPEED_W-1:0] current_speed;
    logic [SPEED_W-1:0] final_speed;
    logic [1:0]         status;
  } out_t;

  // OP_ZERO covers negative query times and the unused function code
  typedef enum logic [2:0] {
    OP_QUERY,
    OP_APPEND,
    OP_CLEAR,
    OP_REJECT,
    OP_ZERO
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [TIME_W-1:0]  t;
    logic [TIME_W-1:0]  end_time;
    logic [SPEED_W-1:0] end_speed;
    logic               is_ramp;
  } cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0]  end_time;
    logic [SPEED_W-1:0] end_speed;
    logic               is_ramp;
  } seg_t;

  localparam int unsigned SEG_W = $bits(seg_t);

  typedef struct packed {
    logic                 start;
    logic [MAG_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: src/spi_ram.sv
`default_nettype none

module spi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                             wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                                  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: src/spi_div.sv
`default_nettype none

module spi_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire spi_pkg::div_req_t req_i,
  output spi_pkg::div_rsp_t      rsp_o
);

  import spi_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0]     quo_q, quo_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] divisor_q, divisor_d;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W+1:0] diff;
  logic                 fits;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign shifted = {rem_q, quo_q[MAG_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor_q};
  assign fits    = !diff[DIVISOR_W+1];

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (req_i.start) begin
      busy_d    = 1'b1;
      cnt_d     = DIV_CNT_W'(MAG_W);
      quo_d     = req_i.dividend;
      rem_d     = '0;
      divisor_d = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[MAG_W-2:0], fits};
      rem_d = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// File: src/spi_front.sv
`default_nettype none

module spi_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire spi_pkg::in_t  in_i,
  output logic               cmd_valid_o,
  output spi_pkg::cmd_t      cmd_o,
  input  wire logic          cmd_pop_i
);

  import spi_pkg::*;

  cmd_t                queue_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0] cnt_q, cnt_d;
  cmd_t                new_cmd;
  logic                push;

  // classify the request before it enters the queue
  always_comb begin
    new_cmd.t         = in_i.query_time[TIME_W-1:0];
    new_cmd.end_time  = in_i.seg_end_time;
    new_cmd.end_speed = in_i.seg_end_speed;
    new_cmd.is_ramp   = (in_i.seg_mode == MODE_RAMP);
    case (in_i.func)
      FUNC_QUERY:  new_cmd.op = in_i.query_time[QTIME_W-1] ? OP_ZERO : OP_QUERY;
      FUNC_APPEND: new_cmd.op = (in_i.seg_mode inside {MODE_STEP, MODE_RAMP}) ?
                                OP_APPEND : OP_REJECT;
      FUNC_CLEAR:  new_cmd.op = OP_CLEAR;
      default:     new_cmd.op = OP_ZERO;
    endcase
  end

  assign in_ready_o  = (cnt_q != QUEUE_CW'(QUEUE_DEPTH));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QUEUE_AW'(1);
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QUEUE_AW'(1);
    end
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + QUEUE_CW'(1);
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_cmd;
    end
  end

`include "speed_profile_interpolator_top_assert.svh"

  `SPI_ASSERT(a_queue_bound, cnt_q <= QUEUE_CW'(QUEUE_DEPTH))
  `SPI_ASSERT(a_push_has_room, push |-> cnt_q != QUEUE_CW'(QUEUE_DEPTH))
  `SPI_ASSERT_MSG(a_pop_nonempty, cmd_pop_i |-> cnt_q != '0, "pop from empty queue")

endmodule

`default_nettype wire

// File: src/spi_back.sv
`default_nettype none

module spi_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire spi_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output spi_pkg::out_t      out_o
);

  import spi_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_EVAL      = 3'd2;
  localparam logic [2:0] S_MUL       = 3'd3;
  localparam logic [2:0] S_DIV_START = 3'd4;
  localparam logic [2:0] S_DIV       = 3'd5;
  localparam logic [2:0] S_OUT       = 3'd6;

  logic [2:0]               state_q, state_d;
  logic [SEG_CW-1:0]        count_q, count_d;
  logic [TIME_W-1:0]        last_end_q, last_end_d;
  logic [SEG_AW-1:0]        k_q, k_d;
  logic                     out_valid_q, out_valid_d;
  out_t                     out_q, out_d;

  logic [TIME_W-1:0]        t_q, t_d;
  logic                     force_last_q, force_last_d;
  seg_t                     prev_q, prev_d;
  seg_t                     seg_q, seg_d;
  logic signed [DIFF_W-1:0] dtime_q, dtime_d;
  logic signed [DV_W-1:0]   dv_q, dv_d;
  logic signed [DIFF_W-1:0] dt_q, dt_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     neg_q, neg_d;
  out_t                     res_q, res_d;

  seg_t                     rd_seg;
  logic                     ram_we;
  logic [SEG_AW-1:0]        ram_raddr;
  logic                     out_free;
  logic                     full;
  logic                     match;
  logic                     is_last;
  logic [PROD_W-1:0]        prod_neg;
  logic [DIFF_W-1:0]        dt_neg;
  logic [SUM_W-1:0]         q_signed;
  logic [SUM_W-1:0]         v_sum;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign out_free  = !out_valid_q || out_ready_i;
  assign full      = (count_q == SEG_CW'(MAX_SEGMENTS));
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i && out_free;
  assign ram_we    = cmd_pop_o && (cmd_i.op == OP_APPEND) && !full;
  // prefetch entry one while idle, then the entry after the one on the read port
  assign ram_raddr = (state_q == S_IDLE) ? SEG_AW'(1) : k_q + SEG_AW'(1);

  // entry zero is never written; the scan starts from a zero start point instead
  spi_ram #(
    .WIDTH (SEG_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[SEG_AW-1:0]),
    .wdata_i ({cmd_i.end_time, cmd_i.end_speed, cmd_i.is_ramp}),
    .raddr_i (ram_raddr),
    .rdata_o (rd_seg)
  );

  spi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign match   = !force_last_q && (t_q >= prev_q.end_time) && (t_q < rd_seg.end_time);
  assign is_last = (SEG_CW'(k_q) == count_q - SEG_CW'(1));

  assign prod_neg = '0 - prod_q;
  assign dt_neg   = '0 - dt_q;
  assign q_signed = neg_q ? ('0 - {2'b00, div_rsp.quotient}) : {2'b00, div_rsp.quotient};
  assign v_sum    = q_signed + SUM_W'(prev_q.end_speed);

  always_comb begin
    div_req.start    = (state_q == S_DIV_START);
    div_req.dividend = prod_q[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod_q[MAG_W-1:0];
    div_req.divisor  = dt_q[DIFF_W-1] ? dt_neg[DIVISOR_W-1:0] : dt_q[DIVISOR_W-1:0];
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    last_end_d   = last_end_q;
    k_d          = k_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    t_d          = t_q;
    force_last_d = force_last_q;
    prev_d       = prev_q;
    seg_d        = seg_q;
    dtime_d      = dtime_q;
    dv_d         = dv_q;
    dt_d         = dt_q;
    prod_d       = prod_q;
    neg_d        = neg_q;
    res_d        = res_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (cmd_pop_o) begin
          out_d.current_speed = '0;
          out_d.final_speed   = '0;
          out_d.status        = STATUS_OK;
          out_valid_d         = 1'b1;
          case (cmd_i.op)
            OP_QUERY: begin
              // with only the zero point present the answer is zero
              if (count_q != SEG_CW'(1)) begin
                out_valid_d  = out_valid_q && !out_ready_i;
                out_d        = out_q;
                t_d          = cmd_i.t;
                force_last_d = (cmd_i.t > last_end_q);
                prev_d       = '0;
                k_d          = SEG_AW'(1);
                state_d      = S_SCAN;
              end
            end
            OP_APPEND: begin
              if (full) begin
                out_d.status = STATUS_FULL;
              end else begin
                count_d    = count_q + SEG_CW'(1);
                last_end_d = cmd_i.end_time;
              end
            end
            OP_CLEAR: begin
              count_d    = SEG_CW'(1);
              last_end_d = '0;
            end
            OP_REJECT: out_d.status = STATUS_BAD_MODE;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // first segment holding t, else the last one
        if (match || is_last) begin
          seg_d   = rd_seg;
          state_d = S_EVAL;
        end else begin
          prev_d = rd_seg;
          k_d    = k_q + SEG_AW'(1);
        end
      end
      S_EVAL: begin
        res_d.final_speed = seg_q.end_speed;
        res_d.status      = STATUS_OK;
        if (!seg_q.is_ramp || (t_q > seg_q.end_time) ||
            (seg_q.end_time == prev_q.end_time)) begin
          res_d.current_speed = seg_q.end_speed;
          state_d             = S_OUT;
        end else begin
          dtime_d = {1'b0, t_q} - {1'b0, prev_q.end_time};
          dv_d    = {1'b0, seg_q.end_speed} - {1'b0, prev_q.end_speed};
          dt_d    = {1'b0, seg_q.end_time} - {1'b0, prev_q.end_time};
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = dtime_q * dv_q;
        state_d = S_DIV_START;
      end
      S_DIV_START: begin
        neg_d   = prod_q[PROD_W-1] ^ dt_q[DIFF_W-1];
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          // clamp to the speed range
          if (v_sum[SUM_W-1]) begin
            res_d.current_speed = '0;
          end else if (|v_sum[SUM_W-2:SPEED_W]) begin
            res_d.current_speed = '1;
          end else begin
            res_d.current_speed = v_sum[SPEED_W-1:0];
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= SEG_CW'(1);
      last_end_q  <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      last_end_q  <= last_end_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q        <= out_d;
    t_q          <= t_d;
    force_last_q <= force_last_d;
    prev_q       <= prev_d;
    seg_q        <= seg_d;
    dtime_q      <= dtime_d;
    dv_q         <= dv_d;
    dt_q         <= dt_d;
    prod_q       <= prod_d;
    neg_q        <= neg_d;
    res_q        <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`include "speed_profile_interpolator_top_assert.svh"

  `SPI_ASSERT(a_count_range,
              count_q >= SEG_CW'(1) && count_q <= SEG_CW'(MAX_SEGMENTS))
  `SPI_ASSERT(a_scan_index,
              state_q == S_SCAN |-> k_q != '0 && SEG_CW'(k_q) < count_q)
  `SPI_ASSERT_MSG(a_result_loaded,
                  state_q == S_OUT && out_free |=> out_valid_q && state_q == S_IDLE,
                  "query result not loaded")

endmodule

`default_nettype wire

// File: src/speed_profile_interpolator_top.sv
`default_nettype none

// Speed profile interpolator. Each request is a query, an append or a clear and
// produces exactly one response. Appends, clears, rejected appends, negative
// query times and queries on an empty profile are answered in the cycle after
// they leave the two-entry request queue. A query is otherwise answered after
// the segment table is scanned up to the selected segment k, one entry per
// cycle, from a RAM with separate read and write ports; a ramp is then finished
// by a multiply and a 48-step restoring divider, one quotient bit per cycle.
// The table holds MAX_SEGMENTS entries including the fixed zero point; it needs
// no clearing pass after reset.
module speed_profile_interpolator_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire spi_pkg::in_t  in_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output spi_pkg::out_t      out_o
);

  import spi_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  spi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  spi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
